// ===== rtl/ictf_pkg.sv =====
// Package for the IMU complementary tilt filter: shared types, register codes,
// command and status structs, and the CORDIC arctangent table.
// No dependencies.
package ictf_pkg;

  localparam int CORDIC_ITER_DEF = 16;
  localparam int ATAN_TABLE_LEN  = 24;
  localparam int ATAN_IDX_W      = 5;

  localparam int GAIN_W   = 16;
  localparam int WEIGHT_W = 17;
  localparam int MAG_W    = 18;
  localparam int ANGLE_W  = 32;
  localparam int SAMPLE_W = 16;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [GAIN_W-1:0]   GAIN_RST     = 16'd10;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 17'd64225;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [MAG_W-1:0]    MAG_LOW_RST  = 18'd8192;
  localparam logic [MAG_W-1:0]    MAG_HIGH_RST = 18'd32768;

  localparam logic signed [ANGLE_W-1:0] ANGLE_180 = 32'sd11796480;

  localparam logic [1:0] REG_GYRO_GAIN      = 2'd0;
  localparam logic [1:0] REG_BLEND_WEIGHT   = 2'd1;
  localparam logic [1:0] REG_MAGNITUDE_LOW  = 2'd2;
  localparam logic [1:0] REG_MAGNITUDE_HIGH = 2'd3;

  typedef struct packed {
    logic [GAIN_W-1:0]   gyro_gain;
    logic [WEIGHT_W-1:0] blend_weight;
    logic [MAG_W-1:0]    magnitude_low;
    logic [MAG_W-1:0]    magnitude_high;
  } ictf_cfg_t;

  typedef enum logic [1:0] {
    MUL_GYRO_X,
    MUL_GYRO_Y,
    MUL_W_OLD,
    MUL_W_ACC
  } ictf_mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GYRO_P,
    ST_GYRO_R,
    ST_SUM_R,
    ST_CINIT,
    ST_CITER,
    ST_BLEND_W,
    ST_BLEND_A,
    ST_BLEND_SUM,
    ST_OUT
  } ictf_state_e;

  typedef struct packed {
    logic          load_in;
    logic          mul_en;
    ictf_mul_sel_e mul_sel;
    logic          pitch_integ;
    logic          roll_integ;
    logic          cordic_init;
    logic          cordic_step;
    logic          blend_upd;
    logic          axis_roll;
    logic          out_load;
  } ictf_cmd_t;

  typedef struct packed {
    logic blend_en;
    logic iter_last;
  } ictf_status_t;

  // atan(2^-i) in degrees, Q16, rounded to nearest
  function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANGLE_W-1:0] r;
    case (idx)
      5'd0:    r = 32'sd2949120;
      5'd1:    r = 32'sd1740967;
      5'd2:    r = 32'sd919879;
      5'd3:    r = 32'sd466945;
      5'd4:    r = 32'sd234379;
      5'd5:    r = 32'sd117304;
      5'd6:    r = 32'sd58666;
      5'd7:    r = 32'sd29335;
      5'd8:    r = 32'sd14668;
      5'd9:    r = 32'sd7334;
      5'd10:   r = 32'sd3667;
      5'd11:   r = 32'sd1833;
      5'd12:   r = 32'sd917;
      5'd13:   r = 32'sd458;
      5'd14:   r = 32'sd229;
      5'd15:   r = 32'sd115;
      5'd16:   r = 32'sd57;
      5'd17:   r = 32'sd29;
      5'd18:   r = 32'sd14;
      5'd19:   r = 32'sd7;
      5'd20:   r = 32'sd4;
      5'd21:   r = 32'sd2;
      5'd22:   r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ictf_regs.sv =====
// APB configuration registers of the tilt filter.
// Depends on ictf_pkg.
module ictf_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ictf_pkg::APB_AW-1:0] paddr,
  input  logic [ictf_pkg::APB_DW-1:0] pwdata,
  output logic [ictf_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output ictf_pkg::ictf_cfg_t         cfg_o
);
  import ictf_pkg::*;

  logic [GAIN_W-1:0]   gain_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [MAG_W-1:0]    low_q;
  logic [MAG_W-1:0]    high_q;
  logic [1:0]          idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RST;
      weight_q <= WEIGHT_RST;
      low_q    <= MAG_LOW_RST;
      high_q   <= MAG_HIGH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_GYRO_GAIN:      gain_q   <= pwdata[GAIN_W-1:0];
        REG_BLEND_WEIGHT:   weight_q <= pwdata[WEIGHT_W-1:0];
        REG_MAGNITUDE_LOW:  low_q    <= pwdata[MAG_W-1:0];
        REG_MAGNITUDE_HIGH: high_q   <= pwdata[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GYRO_GAIN:      prdata = APB_DW'(gain_q);
      REG_BLEND_WEIGHT:   prdata = APB_DW'(weight_q);
      REG_MAGNITUDE_LOW:  prdata = APB_DW'(low_q);
      REG_MAGNITUDE_HIGH: prdata = APB_DW'(high_q);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.gyro_gain      = gain_q;
  assign cfg_o.blend_weight   = weight_q;
  assign cfg_o.magnitude_low  = low_q;
  assign cfg_o.magnitude_high = high_q;

endmodule

// ===== rtl/ictf_ctrl.sv =====
// Sequencing state machine of the tilt filter: handshakes and datapath commands.
// Depends on ictf_pkg.
module ictf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  ictf_pkg::ictf_status_t status_i,
  output ictf_pkg::ictf_cmd_t    cmd_o
);
  import ictf_pkg::*;

  ictf_state_e state_q, state_d;
  logic        axis_q, axis_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_GYRO_P;
      ST_GYRO_P: state_d = ST_GYRO_R;
      ST_GYRO_R: state_d = ST_SUM_R;
      ST_SUM_R: begin
        axis_d  = 1'b0;
        state_d = status_i.blend_en ? ST_CINIT : ST_OUT;
      end
      ST_CINIT:   state_d = ST_CITER;
      ST_CITER:   if (status_i.iter_last) state_d = ST_BLEND_W;
      ST_BLEND_W: state_d = ST_BLEND_A;
      ST_BLEND_A: state_d = ST_BLEND_SUM;
      ST_BLEND_SUM: begin
        if (axis_q) begin
          state_d = ST_OUT;
        end else begin
          axis_d  = 1'b1;
          state_d = ST_CINIT;
        end
      end
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = MUL_GYRO_X;
    cmd_o.axis_roll = axis_q;
    in_stall_o      = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      ST_GYRO_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GYRO_X;
      end
      ST_GYRO_R: begin
        cmd_o.mul_en      = 1'b1;
        cmd_o.mul_sel     = MUL_GYRO_Y;
        cmd_o.pitch_integ = 1'b1;
      end
      ST_SUM_R: cmd_o.roll_integ  = 1'b1;
      ST_CINIT: cmd_o.cordic_init = 1'b1;
      ST_CITER: cmd_o.cordic_step = 1'b1;
      ST_BLEND_W: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_W_OLD;
      end
      ST_BLEND_A: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_W_ACC;
      end
      ST_BLEND_SUM: cmd_o.blend_upd = 1'b1;
      ST_OUT:       cmd_o.out_load  = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/ictf_dp.sv =====
// Datapath of the tilt filter: sample registers, shared multiplier, angle state,
// iterative CORDIC and result registers. Depends on ictf_pkg.
module ictf_dp #(
  parameter int CORDIC_ITERATIONS = ictf_pkg::CORDIC_ITER_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ictf_pkg::ictf_cfg_t                  cfg_i,
  input  ictf_pkg::ictf_cmd_t                  cmd_i,
  output ictf_pkg::ictf_status_t               status_o,
  input  logic signed [ictf_pkg::SAMPLE_W-1:0] accel_x_i,
  input  logic signed [ictf_pkg::SAMPLE_W-1:0] accel_y_i,
  input  logic signed [ictf_pkg::SAMPLE_W-1:0] accel_z_i,
  input  logic signed [ictf_pkg::SAMPLE_W-1:0] gyro_x_i,
  input  logic signed [ictf_pkg::SAMPLE_W-1:0] gyro_y_i,
  output logic signed [ictf_pkg::ANGLE_W-1:0]  pitch_out_o,
  output logic signed [ictf_pkg::ANGLE_W-1:0]  roll_out_o,
  output logic                                 accel_blended_o
);
  import ictf_pkg::*;

  localparam int NUM_ITER = (CORDIC_ITERATIONS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN
                                                                 : CORDIC_ITERATIONS;
  localparam int IW   = $clog2(NUM_ITER);
  localparam int CW   = 34;
  localparam int PW   = 50;
  localparam int SW   = PW + 1;
  localparam int PRE  = 14;

  logic signed [SAMPLE_W-1:0] ax_q, ay_q, az_q, gx_q, gy_q;
  logic signed [ANGLE_W-1:0]  pitch_q, roll_q;
  logic signed [PW-1:0]       prod_q, hold_q;
  logic signed [CW-1:0]       x_q, y_q;
  logic signed [ANGLE_W-1:0]  z_q;
  logic                       zero_q;
  logic [IW-1:0]              iter_q;
  logic signed [ANGLE_W-1:0]  pitch_out_q, roll_out_q;
  logic                       blended_q;

  logic [16:0]                abs_x, abs_y, abs_z;
  logic [MAG_W-1:0]           mag;
  logic [WEIGHT_W-1:0]        w_c;
  logic signed [31:0]         mul_a;
  logic signed [17:0]         mul_b;
  logic signed [PW-1:0]       product;
  logic signed [SW-1:0]       pitch_sum, roll_sum, blend_sum;
  logic signed [ANGLE_W-1:0]  pitch_sat, roll_sat;
  logic signed [SAMPLE_W-1:0] yin, xin;
  logic signed [CW-1:0]       x0, y0, xs, ys;
  logic signed [ANGLE_W-1:0]  t_i;

  function automatic logic [16:0] abs16(input logic [SAMPLE_W-1:0] v);
    return v[SAMPLE_W-1] ? (17'd0 - {1'b1, v}) : {1'b0, v};
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'(64'sh7FFF_FFFF);
    lo = -SW'(64'sh8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[ANGLE_W-1:0];
  endfunction

  // accelerometer magnitude gate
  assign abs_x = abs16(ax_q);
  assign abs_y = abs16(ay_q);
  assign abs_z = abs16(az_q);
  assign mag   = MAG_W'(abs_x) + MAG_W'(abs_y) + MAG_W'(abs_z);
  assign status_o.blend_en  = (mag > cfg_i.magnitude_low) && (mag < cfg_i.magnitude_high);
  assign status_o.iter_last = (iter_q == IW'(NUM_ITER - 1));

  assign w_c = (cfg_i.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg_i.blend_weight;

  // shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_GYRO_X: begin
        mul_a = {{(32 - SAMPLE_W){gx_q[SAMPLE_W-1]}}, gx_q};
        mul_b = {2'b00, cfg_i.gyro_gain};
      end
      MUL_GYRO_Y: begin
        mul_a = {{(32 - SAMPLE_W){gy_q[SAMPLE_W-1]}}, gy_q};
        mul_b = {2'b00, cfg_i.gyro_gain};
      end
      MUL_W_OLD: begin
        mul_a = cmd_i.axis_roll ? roll_q : pitch_q;
        mul_b = {1'b0, w_c};
      end
      MUL_W_ACC: begin
        mul_a = zero_q ? '0 : z_q;
        mul_b = {1'b0, WEIGHT_ONE - w_c};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  assign pitch_sum = {{(SW - ANGLE_W){pitch_q[ANGLE_W-1]}}, pitch_q} + {prod_q[PW-1], prod_q};
  assign roll_sum  = {{(SW - ANGLE_W){roll_q[ANGLE_W-1]}}, roll_q} + {prod_q[PW-1], prod_q};
  assign pitch_sat = sat32(pitch_sum);
  assign roll_sat  = sat32(roll_sum);
  assign blend_sum = {hold_q[PW-1], hold_q} + {prod_q[PW-1], prod_q} + SW'(32768);

  // CORDIC operands: pitch is atan2(ay, az), roll is atan2(ax, az)
  assign xin = az_q;
  assign yin = cmd_i.axis_roll ? ax_q : ay_q;
  assign x0  = {{(CW - SAMPLE_W - PRE){xin[SAMPLE_W-1]}}, xin, {PRE{1'b0}}};
  assign y0  = {{(CW - SAMPLE_W - PRE){yin[SAMPLE_W-1]}}, yin, {PRE{1'b0}}};
  assign xs  = x_q >>> iter_q;
  assign ys  = y_q >>> iter_q;
  assign t_i = atan_q16(ATAN_IDX_W'(iter_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= '0;
      roll_q  <= '0;
      iter_q  <= '0;
    end else begin
      if (cmd_i.pitch_integ) begin
        pitch_q <= pitch_sat;
      end
      if (cmd_i.roll_integ) begin
        roll_q <= roll_sat;
      end
      if (cmd_i.blend_upd) begin
        if (cmd_i.axis_roll) begin
          roll_q <= blend_sum[ANGLE_W+15:16];
        end else begin
          pitch_q <= blend_sum[ANGLE_W+15:16];
        end
      end
      if (cmd_i.cordic_init) begin
        iter_q <= '0;
      end else if (cmd_i.cordic_step) begin
        iter_q <= iter_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gx_q <= gyro_x_i;
      gy_q <= gyro_y_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= product;
      hold_q <= prod_q;
    end
    if (cmd_i.cordic_init) begin
      zero_q <= (xin == '0) && (yin == '0);
      if (xin[SAMPLE_W-1]) begin
        x_q <= -x0;
        y_q <= -y0;
        z_q <= yin[SAMPLE_W-1] ? -ANGLE_180 : ANGLE_180;
      end else begin
        x_q <= x0;
        y_q <= y0;
        z_q <= '0;
      end
    end else if (cmd_i.cordic_step) begin
      if (!y_q[CW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + t_i;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - t_i;
      end
    end
    if (cmd_i.out_load) begin
      pitch_out_q <= pitch_q;
      roll_out_q  <= roll_q;
      blended_q   <= status_o.blend_en;
    end
  end

  assign pitch_out_o     = pitch_out_q;
  assign roll_out_o      = roll_out_q;
  assign accel_blended_o = blended_q;

endmodule

// ===== rtl/imu_complementary_tilt_filter.sv =====
// Top level of the IMU complementary tilt filter: registers, controller, datapath.
// Depends on ictf_pkg, ictf_regs, ictf_ctrl and ictf_dp.
//
// Complementary pitch/roll filter. Each input beat is one IMU sample; each sample
// gives one output beat with the updated pitch and roll angles (degrees, signed
// Q16.16) and a flag telling whether the accelerometer correction was applied.
// Gyro rates are integrated with saturation; when |ax|+|ay|+|az| lies strictly
// between magnitude_low and magnitude_high, both angles are blended with
// accelerometer angles from an iterative CORDIC (pitch from atan2(ay,az), roll
// from atan2(ax,az)). The CORDIC does one rotation per cycle for each axis in
// turn, and the gyro and blend products share the single multiplier. The next
// sample is accepted once the previous result is loaded into the output register;
// a stalled output register holds the filter until it drains. Angles reset to
// zero; registers sit at byte addresses 0, 4, 8 and 12 on the APB port.
module imu_complementary_tilt_filter #(
  parameter int CORDIC_ITERATIONS = ictf_pkg::CORDIC_ITER_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ictf_pkg::APB_AW-1:0]          paddr,
  input  logic [ictf_pkg::APB_DW-1:0]          pwdata,
  output logic [ictf_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ictf_pkg::SAMPLE_W-1:0] accel_x_i,
  input  logic signed [ictf_pkg::SAMPLE_W-1:0] accel_y_i,
  input  logic signed [ictf_pkg::SAMPLE_W-1:0] accel_z_i,
  input  logic signed [ictf_pkg::SAMPLE_W-1:0] gyro_x_i,
  input  logic signed [ictf_pkg::SAMPLE_W-1:0] gyro_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ictf_pkg::ANGLE_W-1:0]  pitch_out_o,
  output logic signed [ictf_pkg::ANGLE_W-1:0]  roll_out_o,
  output logic                                 accel_blended_o
);
  import ictf_pkg::*;

  ictf_cfg_t    cfg;
  ictf_cmd_t    cmd;
  ictf_status_t status;

  ictf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ictf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ictf_dp #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .gyro_x_i        (gyro_x_i),
    .gyro_y_i        (gyro_y_i),
    .pitch_out_o     (pitch_out_o),
    .roll_out_o      (roll_out_o),
    .accel_blended_o (accel_blended_o)
  );

endmodule
